@@ hw/rtl/signed_int_to_decimal_ascii_defines.svh @@
// Assertion macros shared by the signed_int_to_decimal_ascii RTL
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define SITDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds while reset is asserted
`define SITDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/sitda_pkg.sv @@
// Package: types and constants for the signed integer to decimal text converter
`default_nettype none

package sitda_pkg;

  // Width of the input field on the port
  localparam int unsigned FieldW = 32;

  // Bits per BCD digit and per output character
  localparam int unsigned DigitW = 4;
  localparam int unsigned CharW  = 6;

  // ASCII codes, cut to the character width
  localparam logic [CharW-1:0] AsciiZero  = 6'd48;
  localparam logic [CharW-1:0] AsciiMinus = 6'd45;
  localparam logic [CharW-1:0] AsciiNine  = 6'd57;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StEmit
  } state_e;

endpackage

`default_nettype wire

@@ hw/rtl/sitda_dabble.sv @@
// Shared double-dabble unit: add-3 correction on every BCD digit, then one left shift
`default_nettype none

module sitda_dabble
  import sitda_pkg::*;
#(
  parameter int unsigned NDIG  = 10,
  parameter int unsigned BIN_W = 32
) (
  input  logic [NDIG*DigitW-1:0] bcd_i,
  input  logic [BIN_W-1:0]       bin_i,
  output logic [NDIG*DigitW-1:0] bcd_o,
  output logic [BIN_W-1:0]       bin_o
);

  logic [NDIG*DigitW-1:0] corr;

  // Digits of 5 or more get 3 added so the shift carries into the next digit
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_i[i*DigitW +: DigitW] >= 4'd5) begin
        corr[i*DigitW +: DigitW] = bcd_i[i*DigitW +: DigitW] + 4'd3;
      end else begin
        corr[i*DigitW +: DigitW] = bcd_i[i*DigitW +: DigitW];
      end
    end
  end

  // Move the top binary bit into the BCD word
  assign {bcd_o, bin_o} = {corr, bin_i} << 1;

endmodule

`default_nettype wire

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
// Top level: signed integer to ASCII decimal text, one character per output item
//
// channel | handshake               | payload
// --------+-------------------------+-----------------------------
// in      | in_valid_i / in_ready_o | value_i
// out     | out_valid_o/out_ready_i | character_o, last_char_o
//
// A number is accepted in idle, then takes MagW double-dabble steps (32 at the
// default width) on the shared add-3/shift unit, drops leading zeros one per cycle
// with a final check in StSkip, sends the minus sign for a negative number, then
// one digit per cycle while the output is taken. in_ready_o is high only in idle;
// the last character may still wait in the output register while the next number
// is accepted. Reset clears sequencer and out valid.
`default_nettype none

module signed_int_to_decimal_ascii
  import sitda_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FieldW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  character_o,
  output logic              last_char_o
);

`include "signed_int_to_decimal_ascii_defines.svh"

  // Magnitude width, digit count and counter widths
  localparam int unsigned MagW    = (DATA_WIDTH < FieldW) ? DATA_WIDTH : FieldW;
  localparam bit          HasSign = (DATA_WIDTH <= FieldW);
  localparam int unsigned NDig    = (MagW * 301) / 1000 + 1;
  localparam int unsigned BcdW    = NDig * DigitW;
  localparam int unsigned CntW    = $clog2(MagW + 1);
  localparam int unsigned NdW     = $clog2(NDig + 1);

  state_e              state_q, state_d;
  logic [MagW-1:0]     bin_q, bin_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic                neg_q, neg_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [NdW-1:0]      ndig_q, ndig_d;
  logic                out_valid_q, out_valid_d;
  logic [CharW-1:0]    char_q, char_d;
  logic                last_q, last_d;

  logic [MagW-1:0]     in_val;
  logic                in_neg;
  logic [MagW-1:0]     in_mag;
  logic [BcdW-1:0]     step_bcd;
  logic [MagW-1:0]     step_bin;
  logic [DigitW-1:0]   top_digit;
  logic                slot_free;
  logic                load_out;
  logic                lead_zero;
  logic                char_ok;

  // Input cut to the working width, sign and unsigned magnitude
  assign in_val = value_i[MagW-1:0];
  assign in_neg = HasSign && in_val[MagW-1];
  assign in_mag = in_neg ? (~in_val + MagW'(1)) : in_val;

  // Shared conversion step
  sitda_dabble #(
    .NDIG  (NDig),
    .BIN_W (MagW)
  ) u_dabble (
    .bcd_i (bcd_q),
    .bin_i (bin_q),
    .bcd_o (step_bcd),
    .bin_o (step_bin)
  );

  assign top_digit = bcd_q[BcdW-1 -: DigitW];
  assign lead_zero = (top_digit == '0) && (ndig_q != NdW'(1));
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StConv;
      StConv: if (cnt_q == CntW'(1)) state_d = StSkip;
      StSkip: if (!lead_zero) state_d = neg_q ? StSign : StEmit;
      StSign: if (slot_free) state_d = StEmit;
      StEmit: if (slot_free && (ndig_q == NdW'(1))) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath and output loading
  always_comb begin
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    ndig_d   = ndig_q;
    char_d   = char_q;
    last_d   = last_q;
    load_out = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          bin_d  = in_mag;
          neg_d  = in_neg;
          bcd_d  = '0;
          cnt_d  = CntW'(MagW);
          ndig_d = NdW'(NDig);
        end
      end
      StConv: begin
        bin_d = step_bin;
        bcd_d = step_bcd;
        cnt_d = cnt_q - CntW'(1);
      end
      StSkip: begin
        if (lead_zero) begin
          bcd_d  = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          ndig_d = ndig_q - NdW'(1);
        end
      end
      StSign: begin
        if (slot_free) begin
          char_d   = AsciiMinus;
          last_d   = 1'b0;
          load_out = 1'b1;
        end
      end
      StEmit: begin
        if (slot_free) begin
          char_d   = AsciiZero + {{(CharW-DigitW){1'b0}}, top_digit};
          last_d   = (ndig_q == NdW'(1));
          load_out = 1'b1;
          bcd_d    = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          ndig_d   = ndig_q - NdW'(1);
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    cnt_q  <= cnt_d;
    ndig_q <= ndig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

  // Legal output codes: minus sign or a decimal digit
  assign char_ok = (character_o == AsciiMinus) ||
                   ((character_o >= AsciiZero) && (character_o <= AsciiNine));

  // Checks
  `SITDA_ASSERT(a_char_range, out_valid_o |-> char_ok, "character out of range")
  `SITDA_ASSERT(a_minus_not_last, (out_valid_o && (character_o == AsciiMinus)) |-> !last_char_o, "minus sign flagged last")
  `SITDA_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready right after accepting an item")
  `SITDA_ASSERT(a_emit_has_digit, (state_q == StEmit) |-> (ndig_q != '0), "emitting with no digit left")
  `SITDA_ASSERT_ALWAYS(a_no_valid_in_reset, out_valid_o |-> rst_ni, "output valid during reset")

endmodule

`default_nettype wire

@@ sim/tb_signed_int_to_decimal_ascii.sv @@
// Testbench for the signed integer to ASCII decimal text converter
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii
  import sitda_pkg::*;
();

  localparam int unsigned DataW     = 32;
  localparam int unsigned HoldLen   = 300;
  localparam int unsigned DrainWait = 100;
  localparam int unsigned StuckMax  = 3000;
  localparam int unsigned PhaseLen  = 82;

  // One expected character of a converted number
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } text_char_t;

  // Predicts the character stream of each accepted number and checks the output against it
  class decimal_text_board;
    text_char_t  char_q[$];
    int unsigned errors;

    // Turn one accepted number into its expected characters
    function void note_value(logic [FieldW-1:0] v);
      logic [63:0] mask;
      logic [63:0] w;
      logic [63:0] mag;
      logic        neg;
      logic [3:0]  digs[$];
      text_char_t  c;
      mask = (64'd2 << (DataW - 1)) - 64'd1;
      w    = 64'(v) & mask;
      neg  = w[DataW-1];
      mag  = neg ? ((~w + 64'd1) & mask) : w;
      do begin
        digs.push_front(4'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 64'd0);
      if (neg) begin
        c.ch   = AsciiMinus;
        c.last = 1'b0;
        char_q.push_back(c);
      end
      foreach (digs[k]) begin
        c.ch   = AsciiZero + CharW'(digs[k]);
        c.last = (k == digs.size() - 1);
        char_q.push_back(c);
      end
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    // Compare one accepted character with the oldest expectation
    function void check_char(logic [CharW-1:0] ch, logic last);
      text_char_t exp_c;
      if (char_q.size() == 0) begin
        report($sformatf("unexpected character %0d last %0b", ch, last));
        return;
      end
      exp_c = char_q.pop_front();
      if (exp_c.ch !== ch || exp_c.last !== last)
        report($sformatf("mismatch: expected char %0d last %0b, got char %0d last %0b",
                         exp_c.ch, exp_c.last, ch, last));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [FieldW-1:0] value;
  logic              out_valid;
  logic              out_ready;
  logic [CharW-1:0]  character;
  logic              last_char;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned stuck_cnt;

  decimal_text_board board = new();

  signed_int_to_decimal_ascii #(
    .DATA_WIDTH(DataW)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .value_i    (value),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .character_o(character),
    .last_char_o(last_char)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Handshake monitors: note accepted numbers, check accepted characters
  always @(posedge clk) begin
    if (in_valid && in_ready) board.note_value(value);
    if (out_valid && out_ready) board.check_char(character, last_char);
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= StuckMax) begin
      $display("[signed_int_to_decimal_ascii] ERROR");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one number, idling first at the current rate; returns at the falling edge
  task automatic send_value(input logic [FieldW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Let every expected character come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.char_q.size() != 0) @(negedge clk);
  endtask

  // Mix of full-range words, chosen digit counts and the extremes
  function automatic logic [FieldW-1:0] rand_value();
    int unsigned sel;
    int unsigned nd;
    longint      lo;
    longint      hi;
    longint      mag;
    sel = $urandom_range(9);
    if (sel < 3) return $urandom;
    if (sel == 3) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'hffff_ffff;
        default: return 32'h0;
      endcase
    end
    nd = $urandom_range(10, 1);
    lo = 1;
    repeat (nd - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (nd == 1) lo = 0;
    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
    mag = lo + longint'($urandom_range(int'(hi - lo)));
    return $urandom_range(1) ? FieldW'(-mag) : FieldW'(mag);
  endfunction

  logic [FieldW-1:0] directed_q[$];

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    value          = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    stuck_cnt      = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: zero, single digits, digit-count boundaries, extremes, bit patterns
    directed_q = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                   -32'sd9, 32'd1000000000, -32'sd1000000000, 32'd999999999,
                   32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd12345,
                   -32'sd54321, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_fff6,
                   32'd1234567890, 32'd7};
    foreach (directed_q[i]) send_value(directed_q[i]);
    wait_drained();
    @(negedge clk);

    // Receiver holds off for a long stretch while numbers keep coming
    hold_req = hold_req + 1;
    repeat (8) send_value(rand_value());
    wait_drained();
    @(negedge clk);

    // Random phases at different idle and stall rates
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int i = 0; i < PhaseLen; i++) send_value(rand_value());
      if ($urandom_range(1)) begin
        wait_drained();
        @(negedge clk);
      end
    end

    wait_drained();
    repeat (DrainWait) @(posedge clk);
    if (board.errors == 0 && board.char_q.size() == 0) begin
      $display("[signed_int_to_decimal_ascii] OK");
    end else begin
      $display("[signed_int_to_decimal_ascii] ERROR");
    end
    $finish;
  end

endmodule
